/* rtl/jdqc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jdqc_pkg
// shared types and constants of the joystick dead-zone quadratic curve unit
// ----------------------------------------------------------------------------
package jdqc_pkg;

    localparam int SAMPLE_WIDTH_DEF = 8;
    localparam int FULL_SCALE_DEF   = 1024;

    // dead-zone half width register is always 7 bits
    localparam int DEAD_WIDTH       = 7;
    localparam int DEAD_RESET       = 9;

    localparam int CFG_INDEX_WIDTH  = 2;
    localparam int REGION_WIDTH     = 3;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_AXIS_MIN    = 2'd0,
        CFG_AXIS_CENTER = 2'd1,
        CFG_AXIS_MAX    = 2'd2,
        CFG_DEAD_HALF   = 2'd3
    } t_cfg_index;

    typedef enum logic [REGION_WIDTH-1:0] {
        REG_BELOW_MIN = 3'd0,
        REG_NEG_CURVE = 3'd1,
        REG_DEAD_ZONE = 3'd2,
        REG_POS_CURVE = 3'd3,
        REG_FULL_POS  = 3'd4
    } t_region;

endpackage

/* rtl/joystick_deadzone_quadratic_curve_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joystick_deadzone_quadratic_curve_unit
// maps a raw axis sample to a calibrated value with a dead zone and two
// half parabolas, rounded half away from zero
// ----------------------------------------------------------------------------
// Takes one raw sample per clock while o_in_ready is high and returns one
// result per sample, in order. The pipeline is a capture stage, a classify
// stage, a squaring stage, a scale stage, one stage per quotient bit of the
// restoring divider that forms round(FULL_SCALE*d^2/D^2), and the output
// register. Bubbles collapse, so a stalled output only holds the input back
// once every stage is occupied. Configuration writes are taken at any time
// and must be made while the pipeline is empty; the write channel is always
// ready.
module joystick_deadzone_quadratic_curve_unit
    import jdqc_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int FULL_SCALE   = FULL_SCALE_DEF,
    localparam int CFG_WIDTH   = (SAMPLE_WIDTH > DEAD_WIDTH) ? SAMPLE_WIDTH : DEAD_WIDTH,
    localparam int QUOT_WIDTH  = $clog2(FULL_SCALE + 1),
    localparam int VALUE_WIDTH = QUOT_WIDTH + 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [SAMPLE_WIDTH-1:0]       i_raw_sample,

    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [VALUE_WIDTH-1:0] o_curve_value,
    output logic [REGION_WIDTH-1:0]       o_region,

    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0]    i_cfg_index,
    input  logic [CFG_WIDTH-1:0]          i_cfg_data
);

    localparam int SW  = SAMPLE_WIDTH;
    localparam int QW  = QUOT_WIDTH;
    localparam int VW  = VALUE_WIDTH;
    localparam int XW  = CFG_WIDTH + 2;          // signed compare width
    localparam int SQW = 2 * SW;                 // square width
    localparam int DVW = SQW + 1;                // divisor width
    localparam int RW  = SQW + 1 + QW;           // dividend / remainder width
    localparam int NS  = QW + 5;                 // pipeline stages
    localparam int DIV0 = 3;                     // stage holding dividend and divisor
    localparam int OUTS = NS - 1;

    // ------------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------------
    logic [SW-1:0]         r_axis_min;
    logic [SW-1:0]         r_axis_center;
    logic [SW-1:0]         r_axis_max;
    logic [DEAD_WIDTH-1:0] r_dead_half;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis_min    <= '0;
            r_axis_center <= SW'((1 << (SW - 1)) - 1);
            r_axis_max    <= '1;
            r_dead_half   <= DEAD_WIDTH'(DEAD_RESET);
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_AXIS_MIN:    r_axis_min    <= i_cfg_data[SW-1:0];
                CFG_AXIS_CENTER: r_axis_center <= i_cfg_data[SW-1:0];
                CFG_AXIS_MAX:    r_axis_max    <= i_cfg_data[SW-1:0];
                CFG_DEAD_HALF:   r_dead_half   <= i_cfg_data[DEAD_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // stage valids and ready chain
    // ------------------------------------------------------------------------
    logic [NS-1:0] r_vld;
    logic [NS:0]   w_rdy;

    assign w_rdy[NS] = i_out_ready;

    for (genvar k = 0; k < NS; k++) begin : g_rdy
        assign w_rdy[k] = !r_vld[k] || w_rdy[k+1];
    end

    assign o_in_ready  = w_rdy[0];
    assign o_out_valid = r_vld[OUTS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // stage 0: capture sample
    // ------------------------------------------------------------------------
    logic [SW-1:0] r_sample;

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_sample <= i_raw_sample;
        end
    end

    // ------------------------------------------------------------------------
    // stage 1: classify, distance to the dead-zone edge and span
    // ------------------------------------------------------------------------
    logic signed [XW-1:0] w_s, w_mn, w_mx, w_lo, w_hi, w_d, w_q;
    t_region              n_reg1;
    t_region              r_reg1;
    logic [SW-1:0]        r_d1, r_q1;

    always_comb begin
        w_s  = signed'(XW'(r_sample));
        w_mn = signed'(XW'(r_axis_min));
        w_mx = signed'(XW'(r_axis_max));
        w_lo = signed'(XW'(r_axis_center)) - signed'(XW'(r_dead_half));
        w_hi = signed'(XW'(r_axis_center)) + signed'(XW'(r_dead_half));
        w_d  = w_lo - w_s;
        w_q  = w_lo - w_mn;
        if (w_s < w_mn) begin
            n_reg1 = REG_BELOW_MIN;
        end else if (w_s < w_lo) begin
            n_reg1 = REG_NEG_CURVE;
        end else if (w_s > w_hi && w_s < w_mx) begin
            n_reg1 = REG_POS_CURVE;
            w_d    = w_s - w_hi;
            w_q    = w_mx - w_hi;
        end else if (w_s >= w_lo && w_s <= w_hi) begin
            n_reg1 = REG_DEAD_ZONE;
        end else begin
            n_reg1 = REG_FULL_POS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r_reg1 <= n_reg1;
            r_d1   <= w_d[SW-1:0];
            r_q1   <= w_q[SW-1:0];
        end
    end

    // ------------------------------------------------------------------------
    // stage 2: squares
    // ------------------------------------------------------------------------
    t_region        r_reg2;
    logic [SQW-1:0] r_d2, r_q2;

    always_ff @(posedge i_clk) begin
        if (w_rdy[2]) begin
            r_reg2 <= r_reg1;
            r_d2   <= SQW'(r_d1) * SQW'(r_d1);
            r_q2   <= SQW'(r_q1) * SQW'(r_q1);
        end
    end

    // ------------------------------------------------------------------------
    // stage 3 and divider: (2*FS*d^2 + D^2) / (2*D^2), one quotient bit a stage
    // ------------------------------------------------------------------------
    logic [RW-1:0]  r_drem [QW+1];
    logic [DVW-1:0] r_dv   [QW+1];
    logic [QW-1:0]  r_dq   [QW+1];
    t_region        r_dreg [QW+1];

    always_ff @(posedge i_clk) begin
        if (w_rdy[DIV0]) begin
            r_drem[0] <= ((RW'(r_d2) * RW'(FULL_SCALE)) << 1) + RW'(r_q2);
            r_dv[0]   <= DVW'(r_q2) << 1;
            r_dq[0]   <= '0;
            r_dreg[0] <= r_reg2;
        end
    end

    for (genvar j = 0; j < QW; j++) begin : g_div
        localparam int Bit = QW - 1 - j;
        logic [RW-1:0] w_sub;
        logic          w_ge;

        assign w_sub = RW'(r_dv[j]) << Bit;
        assign w_ge  = r_drem[j] >= w_sub;

        always_ff @(posedge i_clk) begin
            if (w_rdy[DIV0+1+j]) begin
                r_drem[j+1] <= w_ge ? (r_drem[j] - w_sub) : r_drem[j];
                r_dv[j+1]   <= r_dv[j];
                r_dq[j+1]   <= (r_dq[j] << 1) | QW'(w_ge);
                r_dreg[j+1] <= r_dreg[j];
            end
        end
    end

    // ------------------------------------------------------------------------
    // output register: sign and saturated regions
    // ------------------------------------------------------------------------
    logic signed [VW-1:0] n_value, r_value;
    logic signed [VW-1:0] w_quot;
    t_region              r_oreg;

    assign w_quot = signed'({1'b0, r_dq[QW]});

    always_comb begin
        case (r_dreg[QW])
            REG_BELOW_MIN: n_value = -signed'(VW'(FULL_SCALE));
            REG_NEG_CURVE: n_value = -w_quot;
            REG_DEAD_ZONE: n_value = '0;
            REG_POS_CURVE: n_value = w_quot;
            default:       n_value = signed'(VW'(FULL_SCALE));
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[OUTS]) begin
            r_value <= n_value;
            r_oreg  <= r_dreg[QW];
        end
    end

    assign o_curve_value = r_value;
    assign o_region      = r_oreg;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_quot_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[OUTS-1] && (r_dreg[QW] == REG_NEG_CURVE || r_dreg[QW] == REG_POS_CURVE)
        |-> r_dq[QW] <= QW'(FULL_SCALE))
        else $error("curve quotient above full scale");

    a_in_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> r_vld[0])
        else $error("accepted sample lost at capture stage");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[0] |-> o_in_ready)
        else $error("input stalled with empty capture stage");

    a_dead_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_region == REG_DEAD_ZONE |-> o_curve_value == '0)
        else $error("dead zone result not zero");

endmodule
